@@ src/lsh_pkg.sv @@
package lsh_pkg;

	// Defaults for the size parameters of the top level.
	localparam int DEF_MAX_WIDTH    = 1024;
	localparam int DEF_MAX_CHANNELS = 4;

	// Sample width shared by the datapath and the line store.
	localparam int SAMPLE_W = 8;

	// Configuration register widths and the write port layout.
	localparam int CFG_WIDTH_W  = 11;
	localparam int CFG_HEIGHT_W = 12;
	localparam int CFG_CHAN_W   = 3;
	localparam int CFG_DATA_W   = 12;
	localparam int CFG_IDX_W    = 2;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_CHANNELS = 2'd2;

	// Register values after reset.
	localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET    = 11'd640;
	localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET   = 12'd480;
	localparam logic [CFG_CHAN_W-1:0]   CHANNELS_RESET = 3'd3;

endpackage

@@ src/laplacian_sharpen_3x3.sv @@
// Channel     | Signals                                   | Transaction
// ------------+-------------------------------------------+------------------------------
// config      | cfg_write, cfg_index, cfg_data            | cfg_write high at a clock edge
// sample in   | sample_valid, sample_stall, sample        | valid high, stall low
// result out  | result_valid, result_stall, value,        | valid high, stall low
//             | last_in_run, frame_end                    |
//
// One sample is accepted per clock while sample_stall is low. Its first result passes
// through the stage 1 register and then the output register, where it is presented.
// Samples of the last row each give two results; the single output register takes the next
// only as the second is taken. All other rows run at one sample per cycle without stalls.
// The line store takes one write and two reads per cycle, which sets the one-sample rate.
// Reset clears the counters, the pipeline valid flags and the registers to their defaults;
// the line store is not cleared. A stall on the result side holds the pipeline and reaches
// sample_stall in the same cycle.
module laplacian_sharpen_3x3
	import lsh_pkg::*;
#(
	parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  sample_valid,
	output logic                  sample_stall,
	input  logic [SAMPLE_W-1:0]   sample,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [SAMPLE_W-1:0]   value,
	output logic                  last_in_run,
	output logic                  frame_end
);

	localparam int ROW_SLOTS = MAX_WIDTH * MAX_CHANNELS;
	localparam int DEPTH     = 2 * ROW_SLOTS;
	localparam int AW        = $clog2(DEPTH);
	localparam int COL_W     = $clog2(ROW_SLOTS);
	localparam int LEN_W     = $clog2(ROW_SLOTS + 1);
	localparam int WP_W      = $clog2(MAX_WIDTH + 1);
	localparam int CH_W      = $clog2(MAX_CHANNELS + 1);
	localparam int WIN       = 2 * MAX_CHANNELS;
	localparam int WI_W      = $clog2(WIN);
	localparam int HI_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	// Per-sample control that travels with the sample into the compute stage.
	typedef struct packed {
		logic            inner;     // result is an interior pixel, not the border ring
		logic            emit;      // the sample causes at least one result
		logic            last_row;  // the sample is in the last input row: two results
		logic            row_end;   // the sample closes its row
		logic            bank;      // line store half that receives this row
		logic            cap_head;  // sample belongs to the first pixel of its row
		logic            use_head;  // left neighbour comes from the saved first pixel
		logic [HI_W-1:0] head_idx;  // channel slot within the first pixel
	} ctl_t;

	// Configuration registers, held raw; out-of-range values are clamped on use.
	logic [CFG_WIDTH_W-1:0]  width_q;
	logic [CFG_HEIGHT_W-1:0] height_q;
	logic [CFG_CHAN_W-1:0]   chan_q;

	// Raster position of the next input sample.
	logic [COL_W-1:0]        col_q;
	logic [CFG_HEIGHT_W-1:0] row_q;

	logic [WP_W-1:0]         eff_w;
	logic [CH_W-1:0]         eff_ch;
	logic [CFG_HEIGHT_W-1:0] eff_h;
	logic [LEN_W-1:0]        row_len;

	always_comb begin
		if (width_q < CFG_WIDTH_W'(3)) begin
			eff_w = WP_W'(3);
		end else if (32'(width_q) > MAX_WIDTH) begin
			eff_w = WP_W'(MAX_WIDTH);
		end else begin
			eff_w = WP_W'(width_q);
		end
		if (chan_q == '0) begin
			eff_ch = CH_W'(1);
		end else if (32'(chan_q) > MAX_CHANNELS) begin
			eff_ch = CH_W'(MAX_CHANNELS);
		end else begin
			eff_ch = CH_W'(chan_q);
		end
		if (height_q < CFG_HEIGHT_W'(3)) begin
			eff_h = CFG_HEIGHT_W'(3);
		end else begin
			eff_h = height_q;
		end
	end

	// Samples per row; a narrow multiply that settles while the block is idle.
	assign row_len = LEN_W'(eff_w) * LEN_W'(eff_ch);

	// Handshake between the input, the compute stage and the output register.
	logic                acc_in;
	logic                adv_s1;
	logic                out_free;
	logic                v_s1;
	logic                out_v_q;
	logic                second_q;
	logic [SAMPLE_W-1:0] sample_s1;
	ctl_t                ctl_s1;

	assign out_free     = !out_v_q || (!result_stall && !second_q);
	assign adv_s1       = v_s1 && (!ctl_s1.emit || out_free);
	assign sample_stall = v_s1 && !adv_s1;
	assign acc_in       = sample_valid && !sample_stall;

	// Stage 0: classify the accepted sample and address the line store. The row below the
	// centre is the incoming sample, the centre row sits in the other half of the store and
	// the row above is read from the half that this sample overwrites.
	logic [LEN_W-1:0] col_ext;
	logic [LEN_W-1:0] ch_ext;
	logic [LEN_W:0]   col_a;
	logic [COL_W-1:0] col_a_safe;
	logic             bank0;
	ctl_t             ctl0;
	logic [AW-1:0]    cur_base;
	logic [AW-1:0]    prev_base;
	logic [AW-1:0]    rd_a_addr;
	logic [AW-1:0]    rd_b_addr;
	logic [AW-1:0]    wr_addr;
	logic             col_wrap;
	logic             row_wrap;

	always_comb begin
		col_ext = LEN_W'(col_q);
		ch_ext  = LEN_W'(eff_ch);
		bank0   = row_q[0];

		ctl0.inner    = (row_q >= CFG_HEIGHT_W'(2)) && (col_ext >= ch_ext)
		                && (col_ext < row_len - ch_ext);
		ctl0.emit     = (row_q != '0);
		ctl0.last_row = ({1'b0, row_q} + (CFG_HEIGHT_W + 1)'(1)) >= {1'b0, eff_h};
		ctl0.row_end  = (col_ext + LEN_W'(1)) == row_len;
		ctl0.bank     = bank0;
		ctl0.cap_head = col_ext < ch_ext;
		ctl0.use_head = col_ext < (ch_ext << 1);
		if (ctl0.cap_head) begin
			ctl0.head_idx = HI_W'(col_q);
		end else begin
			ctl0.head_idx = HI_W'(col_ext - ch_ext);
		end

		// The right neighbour is fetched one pixel ahead. Past the row end it is never used,
		// so any in-range address will do.
		col_a = (LEN_W + 1)'(col_q) + (LEN_W + 1)'(eff_ch);
		if (32'(col_a) < ROW_SLOTS) begin
			col_a_safe = COL_W'(col_a);
		end else begin
			col_a_safe = '0;
		end

		cur_base  = bank0 ? AW'(ROW_SLOTS) : '0;
		prev_base = bank0 ? '0 : AW'(ROW_SLOTS);
		rd_a_addr = prev_base + AW'(col_a_safe);
		rd_b_addr = cur_base + AW'(col_q);
		wr_addr   = cur_base + AW'(col_q);

		col_wrap = (col_ext + LEN_W'(1)) >= row_len;
		row_wrap = ({1'b0, row_q} + (CFG_HEIGHT_W + 1)'(1)) >= {1'b0, eff_h};
	end

	logic [SAMPLE_W-1:0] rd_a_data;
	logic [SAMPLE_W-1:0] rd_b_data;

	// Two rows of samples. The upper neighbour is read from the very entry that the same
	// sample overwrites, and the store returns the old contents for it.
	lsh_line_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk       (clk),
		.rd_en     (acc_in),
		.rd_a_addr (rd_a_addr),
		.rd_b_addr (rd_b_addr),
		.rd_a_data (rd_a_data),
		.rd_b_data (rd_b_data),
		.wr_en     (acc_in),
		.wr_addr   (wr_addr),
		.wr_data   (sample)
	);

	// Configuration writes and the raster counters. A write to a defined index restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			chan_q   <= CHANNELS_RESET;
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_IDX_WIDTH: begin
					width_q <= cfg_data[CFG_WIDTH_W-1:0];
					col_q   <= '0;
					row_q   <= '0;
				end
				CFG_IDX_HEIGHT: begin
					height_q <= cfg_data[CFG_HEIGHT_W-1:0];
					col_q    <= '0;
					row_q    <= '0;
				end
				CFG_IDX_CHANNELS: begin
					chan_q <= cfg_data[CFG_CHAN_W-1:0];
					col_q  <= '0;
					row_q  <= '0;
				end
				default: begin
				end
			endcase
		end else if (acc_in) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_q + CFG_HEIGHT_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Stage 1: the store's read data arrives alongside the sample and its control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc_in) begin
			v_s1 <= 1'b1;
		end else if (adv_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			sample_s1 <= sample;
			ctl_s1    <= ctl0;
		end
	end

	// The centre row streams through a short shift line fed with the look-ahead read, so
	// the centre and left neighbours come from fixed distances of one and two pixels. The
	// first pixel of each row is kept aside, since the shift line has not reached it yet
	// when the second pixel is worked on.
	logic [SAMPLE_W-1:0] win_q  [WIN];
	logic [SAMPLE_W-1:0] head_q [2][MAX_CHANNELS];

	logic [WI_W-1:0]     tap_c;
	logic [WI_W-1:0]     tap_l;
	logic [SAMPLE_W-1:0] centre;
	logic [SAMPLE_W-1:0] left;
	logic [10:0]         centre5;
	logic signed [11:0]  lap;
	logic [SAMPLE_W-1:0] sharp;

	always_comb begin
		tap_c   = WI_W'(eff_ch - CH_W'(1));
		tap_l   = WI_W'({eff_ch, 1'b0} - (CH_W + 1)'(1));
		centre  = win_q[tap_c];
		if (ctl_s1.use_head) begin
			left = head_q[!ctl_s1.bank][ctl_s1.head_idx];
		end else begin
			left = win_q[tap_l];
		end
		centre5 = {1'b0, centre, 2'b00} + {3'b000, centre};
		lap     = $signed({1'b0, centre5}) - $signed({4'b0000, left})
		          - $signed({4'b0000, rd_a_data}) - $signed({4'b0000, rd_b_data})
		          - $signed({4'b0000, sample_s1});
		if (!ctl_s1.inner) begin
			sharp = '0;
		end else if (lap < 12'sd0) begin
			sharp = '0;
		end else if (lap > 12'sd255) begin
			sharp = 8'd255;
		end else begin
			sharp = lap[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			win_q[0] <= rd_a_data;
			for (int k = 1; k < WIN; k++) begin
				win_q[k] <= win_q[k-1];
			end
			if (ctl_s1.cap_head) begin
				head_q[ctl_s1.bank][ctl_s1.head_idx] <= sample_s1;
			end
		end
	end

	// Output register. A last-row sample first shows the result of the row above and then
	// its own border zero, which closes its run.
	logic [SAMPLE_W-1:0] value_q;
	logic                last_q;
	logic                fe_q;
	logic                fe2_q;
	logic                load_out;
	logic                out_acc;

	assign load_out = adv_s1 && ctl_s1.emit;
	assign out_acc  = out_v_q && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			second_q <= 1'b0;
		end else if (load_out) begin
			out_v_q  <= 1'b1;
			second_q <= ctl_s1.last_row;
		end else if (out_acc) begin
			if (second_q) begin
				second_q <= 1'b0;
			end else begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			value_q <= sharp;
			last_q  <= !ctl_s1.last_row;
			fe_q    <= 1'b0;
			fe2_q   <= ctl_s1.row_end;
		end else if (out_acc && second_q) begin
			value_q <= '0;
			last_q  <= 1'b1;
			fe_q    <= fe2_q;
		end
	end

	assign result_valid = out_v_q;
	assign value        = value_q;
	assign last_in_run  = last_q;
	assign frame_end    = fe_q;

endmodule

@@ src/lsh_line_store.sv @@
module lsh_line_store
	import lsh_pkg::*;
#(
	parameter int DEPTH = 2 * DEF_MAX_WIDTH * DEF_MAX_CHANNELS,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_a_addr,
	input  logic [AW-1:0]       rd_b_addr,
	output logic [SAMPLE_W-1:0] rd_a_data,
	output logic [SAMPLE_W-1:0] rd_b_data,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  logic [SAMPLE_W-1:0] wr_data
);

	logic [SAMPLE_W-1:0] mem [DEPTH];

	// A read of the entry being written returns the old contents.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_a_data <= mem[rd_a_addr];
			rd_b_data <= mem[rd_b_addr];
		end
	end

endmodule
